### design/sspl_pkg.sv
package sspl_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam logic [7:0] KING_CODE = 8'd75;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_READ
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_INS,
        CELL_REM,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] kind;
        logic       side;
    } t_entry;

    typedef struct packed {
        t_cell_op   op;
        t_entry     entry;
        logic [5:0] key;
    } t_cell_ctl;

endpackage

### design/sspl_cell.sv
module sspl_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sspl_pkg::t_cell_ctl i_ctl,
    input  sspl_pkg::t_entry   i_left_q,
    input  logic               i_left_occ,
    input  logic               i_left_le,
    input  sspl_pkg::t_entry   i_right_q,
    input  logic               i_right_occ,
    input  sspl_pkg::t_entry   i_head_q,
    output sspl_pkg::t_entry   o_q,
    output logic               o_occ,
    output logic               o_le,
    output logic               o_eq
);
    import sspl_pkg::*;

    t_entry     r_q, n_q;
    logic       r_occ, n_occ;
    logic       r_le, r_ge, r_eq;
    logic       n_le, n_ge, n_eq;
    logic [5:0] key;

    assign key = {r_q.row, r_q.col};

    always_comb begin
        n_q   = r_q;
        n_occ = r_occ;
        n_le  = r_le;
        n_ge  = r_ge;
        n_eq  = r_eq;
        case (i_ctl.op)
            CELL_CMP: begin
                n_le = r_occ && (key <= i_ctl.key);
                n_ge = r_occ && (key >= i_ctl.key);
                n_eq = r_occ && (key == i_ctl.key);
            end
            CELL_INS: begin
                if (!r_le) begin
                    if (i_left_le) begin
                        n_q   = i_ctl.entry;
                        n_occ = 1'b1;
                    end else begin
                        n_q   = i_left_q;
                        n_occ = i_left_occ;
                    end
                end
            end
            CELL_REM: begin
                if (r_ge) begin
                    n_q   = i_right_q;
                    n_occ = i_right_occ;
                end
            end
            CELL_ROT: begin
                n_q = i_right_occ ? i_right_q : i_head_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_le  <= 1'b0;
            r_ge  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_le  <= n_le;
            r_ge  <= n_ge;
            r_eq  <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q   = r_q;
    assign o_occ = r_occ;
    assign o_le  = r_le;
    assign o_eq  = r_eq;

endmodule

### design/sorted_square_piece_list.sv
// channel   direction  handshake          payload
// request   in         i_valid / o_stall  i_mode i_row i_col i_kind i_side
// result    out        o_valid / i_stall  o_status o_out_* o_last o_*_king_*
//
// Insert, remove: accept, compare in every cell, then shift the chain.
// Readout: accept and compare, then the chain rotates once per held entry, emitting at most MAX_RESULTS of them.
// Synchronous active-low reset empties the list and clears both king records.
// A stalled result holds the next request in its apply step, or the readout in place.
module sorted_square_piece_list #(
    parameter int CAPACITY = sspl_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [2:0] i_row,
    input  logic [2:0] i_col,
    input  logic [7:0] i_kind,
    input  logic       i_side,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic       o_out_valid,
    output logic [2:0] o_out_row,
    output logic [2:0] o_out_col,
    output logic [7:0] o_out_kind,
    output logic       o_out_side,
    output logic       o_last,
    output logic       o_cpu_king_valid,
    output logic [5:0] o_cpu_king_square,
    output logic       o_human_king_valid,
    output logic [5:0] o_human_king_square
);
    import sspl_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int LIM = (MAX_RESULTS > CAPACITY) ? CAPACITY : MAX_RESULTS;
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
    localparam logic [CW-1:0] LIM_W = CW'(LIM);

    t_state        r_state, n_state;
    t_mode         r_mode;
    t_entry        r_req;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_step, n_step;
    logic [1:0]    r_king_known, n_king_known;
    logic [5:0]    r_king_sq [2];
    logic [5:0]    n_king_sq [2];

    logic          r_o_valid, n_o_valid;
    t_status       r_o_status, n_o_status;
    logic          r_o_out_valid, n_o_out_valid;
    t_entry        r_o_entry, n_o_entry;
    logic          r_o_last, n_o_last;
    logic [1:0]    r_o_king_known, n_o_king_known;
    logic [5:0]    r_o_king_sq [2];
    logic [5:0]    n_o_king_sq [2];

    t_cell_ctl     cell_ctl;
    t_entry        cell_q [CAPACITY];
    logic [CAPACITY-1:0] occ, le, eq;

    logic          out_free, full, empty, found, is_king;
    logic          emit_step, advance;
    logic [CW-1:0] read_n;

    assign out_free  = !r_o_valid || !i_stall;
    assign full      = (r_fill == CAP_W);
    assign empty     = (r_fill == '0);
    assign found     = |eq;
    assign is_king   = (r_req.kind == KING_CODE);
    assign read_n    = (r_fill > LIM_W) ? LIM_W : r_fill;
    assign emit_step = (r_step < LIM_W);
    assign advance   = emit_step ? out_free : 1'b1;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry left_q, right_q;
            logic   left_occ, left_le, right_occ;
            if (g == 0) begin : g_head
                assign left_q   = '0;
                assign left_occ = 1'b0;
                assign left_le  = 1'b1;
            end else begin : g_body
                assign left_q   = cell_q[g-1];
                assign left_occ = occ[g-1];
                assign left_le  = le[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign right_q   = cell_q[g];
                assign right_occ = 1'b0;
            end else begin : g_mid
                assign right_q   = cell_q[g+1];
                assign right_occ = occ[g+1];
            end
            sspl_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (cell_ctl),
                .i_left_q    (left_q),
                .i_left_occ  (left_occ),
                .i_left_le   (left_le),
                .i_right_q   (right_q),
                .i_right_occ (right_occ),
                .i_head_q    (cell_q[0]),
                .o_q         (cell_q[g]),
                .o_occ       (occ[g]),
                .o_le        (le[g]),
                .o_eq        (eq[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CMP;
            end
            S_CMP: begin
                n_state = (r_mode == MODE_NONE) ? S_IDLE : S_APPLY;
            end
            S_APPLY: begin
                if (out_free) n_state = (r_mode == MODE_READ && !empty) ? S_READ : S_IDLE;
            end
            S_READ: begin
                if (advance && r_step == r_fill - CW'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cell_ctl.op    = CELL_HOLD;
        cell_ctl.entry = r_req;
        cell_ctl.key   = {r_req.row, r_req.col};
        n_fill         = r_fill;
        n_step         = r_step;
        n_king_known   = r_king_known;
        n_king_sq      = r_king_sq;
        n_o_valid      = r_o_valid && i_stall;
        n_o_status     = r_o_status;
        n_o_out_valid  = r_o_out_valid;
        n_o_entry      = r_o_entry;
        n_o_last       = r_o_last;
        case (r_state)
            S_CMP: begin
                cell_ctl.op = CELL_CMP;
            end
            S_APPLY: begin
                if (out_free) begin
                    n_step = '0;
                    if (!(r_mode == MODE_READ && !empty)) begin
                        n_o_valid     = 1'b1;
                        n_o_status    = ST_OK;
                        n_o_out_valid = 1'b0;
                        n_o_entry     = '0;
                        n_o_last      = 1'b1;
                    end
                    case (r_mode)
                        MODE_INSERT: begin
                            if (full) begin
                                n_o_status = ST_FULL;
                            end else begin
                                cell_ctl.op = CELL_INS;
                                n_fill      = r_fill + CW'(1);
                                if (is_king) begin
                                    n_king_known[r_req.side] = 1'b1;
                                    n_king_sq[r_req.side]    = {r_req.row, r_req.col};
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            if (empty) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                if (is_king) begin
                                    n_king_known[r_req.side] = 1'b0;
                                    n_king_sq[r_req.side]    = '0;
                                end
                                if (!found) begin
                                    n_o_status = ST_MISSING;
                                end else begin
                                    cell_ctl.op = CELL_REM;
                                    n_fill      = r_fill - CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (advance) begin
                    cell_ctl.op = CELL_ROT;
                    n_step      = r_step + CW'(1);
                    if (emit_step) begin
                        n_o_valid     = 1'b1;
                        n_o_status    = ST_OK;
                        n_o_out_valid = 1'b1;
                        n_o_entry     = cell_q[0];
                        n_o_last      = (r_step == read_n - CW'(1));
                    end
                end
            end
            default: begin
            end
        endcase
        n_o_king_known = n_king_known;
        n_o_king_sq    = n_king_sq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_step       <= '0;
            r_king_known <= '0;
            r_king_sq[0] <= '0;
            r_king_sq[1] <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fill       <= n_fill;
            r_step       <= n_step;
            r_king_known <= n_king_known;
            r_king_sq    <= n_king_sq;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_mode <= t_mode'(i_mode);
            r_req  <= '{row: i_row, col: i_col, kind: i_kind, side: i_side};
        end
        r_o_status     <= n_o_status;
        r_o_out_valid  <= n_o_out_valid;
        r_o_entry      <= n_o_entry;
        r_o_last       <= n_o_last;
        r_o_king_known <= n_o_king_known;
        r_o_king_sq    <= n_o_king_sq;
    end

    assign o_stall             = (r_state != S_IDLE);
    assign o_valid             = r_o_valid;
    assign o_status            = r_o_status;
    assign o_out_valid         = r_o_out_valid;
    assign o_out_row           = r_o_entry.row;
    assign o_out_col           = r_o_entry.col;
    assign o_out_kind          = r_o_entry.kind;
    assign o_out_side          = r_o_entry.side;
    assign o_last              = r_o_last;
    assign o_cpu_king_valid    = r_o_king_known[1];
    assign o_cpu_king_square   = r_o_king_sq[1];
    assign o_human_king_valid  = r_o_king_known[0];
    assign o_human_king_square = r_o_king_sq[0];

endmodule

### design/sspl_checker.sv
module sspl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic       o_out_valid,
    input logic [2:0] o_out_row,
    input logic [2:0] o_out_col,
    input logic       o_last,
    input logic       o_cpu_king_valid,
    input logic [5:0] o_cpu_king_square,
    input logic       o_human_king_valid,
    input logic [5:0] o_human_king_square
);
    import sspl_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_last)
        else $error("status result not marked last");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> o_status == ST_OK)
        else $error("list entry with error status");

    a_king_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_cpu_king_valid || !o_human_king_valid) |->
            (o_cpu_king_valid || o_cpu_king_square == 6'd0) &&
            (o_human_king_valid || o_human_king_square == 6'd0))
        else $error("cleared king record holds a square");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_row) && $stable(o_out_col))
        else $error("stalled result changed");

endmodule

bind sorted_square_piece_list sspl_checker u_sspl_checker (.*);
